@@ rtl/rpn_pkg.sv @@
// Shared types and constants of the RPN stack calculator.
// Holds field widths, operation and status codes, and the controller/datapath interface.
// No dependencies.
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 3;
    localparam int IDX_W           = 5;
    localparam int ST_W            = 2;
    localparam int DEF_STACK_DEPTH = 32;
    localparam int TDATA_IN_W      = 32;
    localparam int TUSER_IN_W      = 3;
    localparam int TDATA_OUT_W     = 40;
    localparam int TUSER_OUT_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5,
        OP_SWAP = 3'd6,
        OP_DUP  = 3'd7
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_SEC,
        S_EXEC,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_WRITE,
        S_SWAP2,
        S_DUMP_GO,
        S_DUMP
    } t_state;

    typedef enum logic [2:0] {
        WS_NONE,
        WS_PUSH,
        WS_TOP,
        WS_SEC,
        WS_ALU,
        WS_RES,
        WS_DIV
    } t_wsrc;

    typedef enum logic [1:0] {
        WA_D,
        WA_D1,
        WA_D2
    } t_waddr;

    typedef enum logic [1:0] {
        DU_HOLD,
        DU_INC,
        DU_DEC
    } t_dupd;

    typedef struct packed {
        logic   latch_in;
        logic   rd_top;
        logic   rd_sec;
        logic   cap_top;
        logic   cap_sec;
        logic   set_status;
        logic   mul_en;
        logic   div_start;
        t_wsrc  wsrc;
        t_waddr waddr;
        t_dupd  dupd;
        logic   dump_start;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic err;
        logic div_done;
        logic dump_done;
    } t_stat;

endpackage

@@ rtl/rpn_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_div
    import rpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic [DATA_W-1:0] o_quo,
    output logic              o_done
);

    localparam int CW = $clog2(DATA_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(DATA_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   n_rem;
    logic              n_bit;

    always_comb begin
        shifted = {r_rem[DATA_W-1:0], r_q[DATA_W-1]};
        diff    = shifted - {1'b0, r_den};
        n_bit   = ~diff[DATA_W];
        n_rem   = n_bit ? diff : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num[DATA_W-1] ? ('0 - i_num) : i_num;
            r_den <= i_den[DATA_W-1] ? ('0 - i_den) : i_den;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[DATA_W-2:0], n_bit};
        end
    end

    assign o_quo  = r_neg ? ('0 - r_q) : r_q;
    assign o_done = r_done;

endmodule

@@ rtl/rpn_dp.sv @@
// Datapath of the RPN stack calculator: stack memory, depth, operand and result
// registers, arithmetic, the stack dump stream and the output register.
// Depends on rpn_pkg and rpn_div.
module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_push_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_elem_value,
    output logic [IDX_W-1:0]  o_elem_index,
    output logic              o_stack_empty,
    output logic [ST_W-1:0]   o_status,
    output logic              o_last
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];
    logic [DATA_W-1:0] r_rdata;

    t_op               r_op;
    logic [DATA_W-1:0] r_push;
    logic [DW-1:0]     r_depth;
    logic [DATA_W-1:0] r_top;
    logic [DATA_W-1:0] r_sec;
    logic [DATA_W-1:0] r_res;
    t_status           r_status;

    logic              r_dact;
    logic [DW-1:0]     r_didx;
    logic              r_pv;
    logic [DW-1:0]     r_pidx;
    logic              r_plast;
    logic              r_pempty;

    logic              r_ovalid;
    logic [DATA_W-1:0] r_oval;
    logic [IDX_W-1:0]  r_oidx;
    logic              r_oempty;
    t_status           r_ostatus;
    logic              r_olast;

    t_status                  n_status;
    logic                     need1;
    logic                     need2;
    logic [DW-1:0]            depth_m1;
    logic [DW-1:0]            depth_m2;
    logic [DATA_W-1:0]        alu;
    logic [2*DATA_W-1:0]      prod;
    logic [DATA_W-1:0]        div_quo;
    logic                     div_done;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     load;
    logic                     issue;
    logic                     idx_last;
    logic [DW+IDX_W-1:0]      pidx_ext;

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sec),
        .i_den   (r_top),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    always_comb begin
        depth_m1 = r_depth - DW'(1);
        depth_m2 = r_depth - DW'(2);
        need1    = (r_op == OP_POP) || (r_op == OP_DUP);
        need2    = r_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP};
        n_status = ST_OK;
        if ((need1 && (r_depth == '0)) || (need2 && (r_depth < DW'(2)))) begin
            n_status = ST_UNDER;
        end else if (((r_op == OP_PUSH) || (r_op == OP_DUP)) && (r_depth == FULL)) begin
            n_status = ST_OVER;
        end else if ((r_op == OP_DIV) && (r_top == '0)) begin
            n_status = ST_DIVZ;
        end
    end

    assign alu  = (r_op == OP_SUB) ? (r_sec - r_top) : (r_sec + r_top);
    assign prod = r_sec * r_top;

    always_comb begin
        wr_data = r_push;
        case (i_cmd.wsrc)
            WS_PUSH: wr_data = r_push;
            WS_TOP:  wr_data = r_top;
            WS_SEC:  wr_data = r_sec;
            WS_ALU:  wr_data = alu;
            WS_RES:  wr_data = r_res;
            WS_DIV:  wr_data = div_quo;
            default: wr_data = r_push;
        endcase
        case (i_cmd.waddr)
            WA_D:    wr_addr = r_depth[AW-1:0];
            WA_D1:   wr_addr = depth_m1[AW-1:0];
            WA_D2:   wr_addr = depth_m2[AW-1:0];
            default: wr_addr = r_depth[AW-1:0];
        endcase
        wr_en = (i_cmd.wsrc != WS_NONE);
    end

    assign load     = r_pv && (!r_ovalid || i_ready);
    assign issue    = r_dact && (!r_pv || load);
    assign idx_last = ((r_didx + DW'(1)) == r_depth);
    assign rd_en    = issue || i_cmd.rd_top || i_cmd.rd_sec;

    always_comb begin
        if (issue) begin
            rd_addr = r_didx[AW-1:0];
        end else if (i_cmd.rd_top) begin
            rd_addr = depth_m1[AW-1:0];
        end else begin
            rd_addr = depth_m2[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_dact   <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_cmd.dupd)
                DU_INC:  r_depth <= r_depth + DW'(1);
                DU_DEC:  r_depth <= r_depth - DW'(1);
                default: r_depth <= r_depth;
            endcase
            if (i_cmd.dump_start) begin
                if (r_depth == '0) begin
                    r_pv   <= 1'b1;
                    r_dact <= 1'b0;
                end else begin
                    r_dact <= 1'b1;
                end
            end else if (issue) begin
                r_pv <= 1'b1;
                if (idx_last) begin
                    r_dact <= 1'b0;
                end
            end else if (load) begin
                r_pv <= 1'b0;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign pidx_ext = {{IDX_W{1'b0}}, r_pidx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= t_op'(i_op);
            r_push <= i_push_value;
        end
        if (i_cmd.cap_top) begin
            r_top <= r_rdata;
        end
        if (i_cmd.cap_sec) begin
            r_sec <= r_rdata;
        end
        if (i_cmd.set_status) begin
            r_status <= n_status;
        end
        if (i_cmd.mul_en) begin
            r_res <= prod[DATA_W-1:0];
        end
        if (i_cmd.dump_start) begin
            r_didx   <= '0;
            r_pidx   <= '0;
            r_plast  <= 1'b1;
            r_pempty <= (r_depth == '0);
        end else if (issue) begin
            r_didx   <= r_didx + DW'(1);
            r_pidx   <= r_didx;
            r_plast  <= idx_last;
            r_pempty <= 1'b0;
        end
        if (load) begin
            r_oval    <= r_pempty ? '0 : r_rdata;
            r_oidx    <= r_pempty ? '0 : pidx_ext[IDX_W-1:0];
            r_oempty  <= r_pempty;
            r_ostatus <= r_status;
            r_olast   <= r_plast;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.err       = (n_status != ST_OK);
    assign o_stat.div_done  = div_done;
    assign o_stat.dump_done = load && r_plast;

    assign o_valid       = r_ovalid;
    assign o_elem_value  = r_oval;
    assign o_elem_index  = r_oidx;
    assign o_stack_empty = r_oempty;
    assign o_status      = r_ostatus;
    assign o_last        = r_olast;

endmodule

@@ rtl/rpn_ctrl.sv @@
// Controller state machine of the RPN stack calculator.
// Sequences operand reads, the operation, stack writes and the dump. Depends on rpn_pkg.
module rpn_ctrl
    import rpn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_RD_TOP;
                end
            end
            S_RD_TOP: begin
                o_cmd.rd_top = 1'b1;
                n_state      = S_RD_SEC;
            end
            S_RD_SEC: begin
                o_cmd.cap_top = 1'b1;
                o_cmd.rd_sec  = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.cap_sec    = 1'b1;
                o_cmd.set_status = 1'b1;
                if (i_stat.err) begin
                    n_state = S_DUMP_GO;
                end else begin
                    case (i_stat.op)
                        OP_MUL:  n_state = S_MUL;
                        OP_DIV:  n_state = S_DIV_GO;
                        default: n_state = S_WRITE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_WRITE;
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_DUMP_GO;
                case (i_stat.op)
                    OP_PUSH: begin
                        o_cmd.wsrc  = WS_PUSH;
                        o_cmd.waddr = WA_D;
                        o_cmd.dupd  = DU_INC;
                    end
                    OP_POP: begin
                        o_cmd.dupd = DU_DEC;
                    end
                    OP_DUP: begin
                        o_cmd.wsrc  = WS_TOP;
                        o_cmd.waddr = WA_D;
                        o_cmd.dupd  = DU_INC;
                    end
                    OP_ADD, OP_SUB: begin
                        o_cmd.wsrc  = WS_ALU;
                        o_cmd.waddr = WA_D2;
                        o_cmd.dupd  = DU_DEC;
                    end
                    OP_MUL: begin
                        o_cmd.wsrc  = WS_RES;
                        o_cmd.waddr = WA_D2;
                        o_cmd.dupd  = DU_DEC;
                    end
                    OP_DIV: begin
                        o_cmd.wsrc  = WS_DIV;
                        o_cmd.waddr = WA_D2;
                        o_cmd.dupd  = DU_DEC;
                    end
                    OP_SWAP: begin
                        o_cmd.wsrc  = WS_TOP;
                        o_cmd.waddr = WA_D2;
                        n_state     = S_SWAP2;
                    end
                    default: begin
                        n_state = S_DUMP_GO;
                    end
                endcase
            end
            S_SWAP2: begin
                o_cmd.wsrc  = WS_SEC;
                o_cmd.waddr = WA_D1;
                n_state     = S_DUMP_GO;
            end
            S_DUMP_GO: begin
                o_cmd.dump_start = 1'b1;
                n_state          = S_DUMP;
            end
            S_DUMP: begin
                if (i_stat.dump_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rpn_stack_calculator.sv @@
// Top level of the RPN stack calculator: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_dp.
//
//  Channel   Direction  Ports               Contents (lowest bit first)
//  s_axis    in         tvalid/tready/data  tuser: op[2:0]; tdata: push_value[31:0]
//  m_axis    out        tvalid/tready/data  tdata: elem_value, elem_index, 3'b0;
//                                           tuser: stack_empty, status; tlast: last
//
// A request reads the top two entries and is checked; a failed one goes to the dump, the
// others write back: multiply after a product step, swap with a second write, divide
// once the divider, one quotient bit per cycle, is done. The dump then streams one element
// per cycle, unless the output stalls, through the single read port of the stack memory,
// and a single zero element when the stack is empty. Reset is synchronous and clears the
// depth, the controller and the output valid flag. A stalled output holds the dump; the
// next request is taken once the last element of the dump sits in the output register.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // push_value[31:0]
    input  logic [TUSER_IN_W-1:0]  s_axis_tuser,   // op[2:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // elem_value[31:0], elem_index[36:32], zero
    output logic [TUSER_OUT_W-1:0] m_axis_tuser,   // stack_empty[0], status[2:1]
    output logic                   m_axis_tlast
);

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] elem_value;
    logic [IDX_W-1:0]  elem_index;
    logic              stack_empty;
    logic [ST_W-1:0]   status;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (s_axis_tuser[OP_W-1:0]),
        .i_push_value  (s_axis_tdata[DATA_W-1:0]),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_elem_value  (elem_value),
        .o_elem_index  (elem_index),
        .o_stack_empty (stack_empty),
        .o_status      (status),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TDATA_OUT_W - DATA_W - IDX_W){1'b0}}, elem_index, elem_value};
    assign m_axis_tuser = {status, stack_empty};

endmodule

@@ rtl/rpn_chk.sv @@
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_calculator.
module rpn_chk
    import rpn_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input logic [TUSER_OUT_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty stack result is not a single zero result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the previous one is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind rpn_stack_calculator rpn_chk u_rpn_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ test/rpn_stack_calculator_check.sv @@
// Checker for the RPN stack calculator: watches the request and dump channels.
// Predicts every stack dump from accepted requests and compares it element by element.
// Depends on rpn_pkg.
module rpn_stack_calculator_check
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [TUSER_IN_W-1:0]  i_req_op,
    input  logic [TDATA_IN_W-1:0]  i_req_value,
    input  logic                   i_dump_valid,
    input  logic                   i_dump_ready,
    input  logic [TDATA_OUT_W-1:0] i_dump_data,
    input  logic [TUSER_OUT_W-1:0] i_dump_user,
    input  logic                   i_dump_last,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              empty;
        t_status           status;
        logic              last;
    } dump_elem_t;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int                depth;
    dump_elem_t        expected_dump [$];
    int                mismatches;

    function automatic t_status run_op(input t_op op, input logic [DATA_W-1:0] operand);
        logic [DATA_W-1:0] top_v;
        logic [DATA_W-1:0] sec_v;
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] mag_d;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] res;
        if (op == OP_PUSH) begin
            if (depth >= STACK_DEPTH) return ST_OVER;
            stack_mem[depth] = operand;
            depth++;
            return ST_OK;
        end
        if (op == OP_POP) begin
            if (depth < 1) return ST_UNDER;
            depth--;
            return ST_OK;
        end
        if (op == OP_DUP) begin
            if (depth < 1) return ST_UNDER;
            if (depth >= STACK_DEPTH) return ST_OVER;
            stack_mem[depth] = stack_mem[depth-1];
            depth++;
            return ST_OK;
        end
        if (depth < 2) return ST_UNDER;
        top_v = stack_mem[depth-1];
        sec_v = stack_mem[depth-2];
        case (op)
            OP_ADD: res = sec_v + top_v;
            OP_SUB: res = sec_v - top_v;
            OP_MUL: res = sec_v * top_v;
            OP_DIV: begin
                if (top_v == '0) return ST_DIVZ;
                mag_n = sec_v[DATA_W-1] ? -sec_v : sec_v;
                mag_d = top_v[DATA_W-1] ? -top_v : top_v;
                quo   = mag_n / mag_d;
                res   = (sec_v[DATA_W-1] ^ top_v[DATA_W-1]) ? -quo : quo;
            end
            default: begin
                stack_mem[depth-2] = top_v;
                stack_mem[depth-1] = sec_v;
                return ST_OK;
            end
        endcase
        stack_mem[depth-2] = res;
        depth--;
        return ST_OK;
    endfunction

    task automatic queue_dump(input t_status status);
        dump_elem_t elem;
        if (depth == 0) begin
            elem = '{value: '0, index: '0, empty: 1'b1, status: status, last: 1'b1};
            expected_dump.push_back(elem);
        end else begin
            for (int i = 0; i < depth; i++) begin
                elem.value  = stack_mem[i];
                elem.index  = i[IDX_W-1:0];
                elem.empty  = 1'b0;
                elem.status = status;
                elem.last   = (i == depth - 1);
                expected_dump.push_back(elem);
            end
        end
    endtask

    always @(posedge i_clk) begin
        dump_elem_t want;
        dump_elem_t got;
        if (!i_rst_n) begin
            depth = 0;
            mismatches = 0;
            expected_dump.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                queue_dump(run_op(t_op'(i_req_op), i_req_value));
            end
            if (i_dump_valid && i_dump_ready) begin
                got.value  = i_dump_data[DATA_W-1:0];
                got.index  = i_dump_data[DATA_W+IDX_W-1:DATA_W];
                got.empty  = i_dump_user[0];
                got.status = t_status'(i_dump_user[2:1]);
                got.last   = i_dump_last;
                if (expected_dump.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected dump element, expected none", $time);
                    $display("%0t:   actual %h idx %0d empty %b status %0d last %b",
                             $time, got.value, got.index, got.empty, got.status, got.last);
                end else begin
                    want = expected_dump.pop_front();
                    if (got.value !== want.value || got.index !== want.index ||
                        got.empty !== want.empty || got.status !== want.status ||
                        got.last !== want.last) begin
                        mismatches++;
                        $display("%0t: expected %h idx %0d empty %b status %0d last %b",
                                 $time, want.value, want.index, want.empty, want.status,
                                 want.last);
                        $display("%0t:   actual %h idx %0d empty %b status %0d last %b",
                                 $time, got.value, got.index, got.empty, got.status,
                                 got.last);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_dump.size();
    end

endmodule

@@ test/rpn_stack_calculator_test.sv @@
// Top of the RPN stack calculator testbench: clock, reset, request stimulus and verdict.
// Drives directed and random operations with bursty requests and a stalling dump receiver.
// Depends on rpn_pkg, rpn_stack_calculator and rpn_stack_calculator_check.
module rpn_stack_calculator_test;
    import rpn_pkg::*;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    logic [TUSER_IN_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [TUSER_OUT_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;
    int                     fail_count;
    int                     pending;
    int                     burst_left;
    int                     requests_sent;

    rpn_stack_calculator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rpn_stack_calculator_check dump_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_op     (s_axis_tuser),
        .i_req_value  (s_axis_tdata),
        .i_dump_valid (m_axis_tvalid),
        .i_dump_ready (m_axis_tready),
        .i_dump_data  (m_axis_tdata),
        .i_dump_user  (m_axis_tuser),
        .i_dump_last  (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("rpn_stack_calculator_test failed");
        $finish;
    end

    initial begin
        int mode;
        int span;
        m_axis_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ((k % 16) < 4);
                endcase
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_op op, input logic [DATA_W-1:0] operand);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= operand;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        requests_sent++;
    endtask

    task automatic drain_dumps();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_any(input t_op op);
        send_request(op, (op == OP_PUSH) ? rand_operand() : $urandom);
    endtask

    t_op               directed_ops  [24] = '{
        OP_POP, OP_DUP, OP_ADD, OP_PUSH, OP_SWAP, OP_DIV, OP_PUSH, OP_ADD,
        OP_PUSH, OP_DIV, OP_PUSH, OP_DIV, OP_POP, OP_PUSH, OP_PUSH, OP_DIV,
        OP_MUL, OP_PUSH, OP_SUB, OP_DUP, OP_SWAP, OP_DIV, OP_POP, OP_POP
    };
    logic [DATA_W-1:0] directed_vals [24] = '{
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'hA5A5_A5A5, 32'h0000_0000, 32'h0000_0001, 32'h5A5A_5A5A,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h1234_5678, 32'h0000_0007, 32'hFFFF_FFFE, 32'h8000_0000,
        32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0F0F_0F0F, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF
    };

    initial begin
        int  kind;
        int  len;
        int  pick;
        t_op op;
        bit  first_episode;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUSH;
        burst_left    = 0;
        requests_sent = 0;
        first_episode = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 24; i++) begin
            send_request(directed_ops[i], directed_vals[i]);
        end
        drain_dumps();

        while (requests_sent < 464) begin
            kind = first_episode ? 0 : $urandom_range(0, 9);
            first_episode = 1'b0;
            if (kind <= 1) begin
                send_any(OP_PUSH);
                len = $urandom_range(39, 44);
                repeat (len) send_any(($urandom_range(0, 3) == 0) ? OP_DUP : OP_PUSH);
            end else if (kind <= 3) begin
                len = $urandom_range(20, 45);
                repeat (len) begin
                    pick = $urandom_range(0, 9);
                    if (pick <= 3) op = OP_POP;
                    else if (pick == 4) op = OP_SWAP;
                    else op = t_op'($urandom_range(OP_ADD, OP_DIV));
                    send_any(op);
                end
            end else if (kind <= 7) begin
                len = $urandom_range(3, 10);
                repeat (len) begin
                    send_any(OP_PUSH);
                    send_any(OP_PUSH);
                    pick = $urandom_range(0, 5);
                    if (pick == 0) send_any(OP_SWAP);
                    else if (pick == 1) send_any(OP_DUP);
                    send_any(t_op'($urandom_range(OP_ADD, OP_DIV)));
                    if ($urandom_range(0, 1) == 1) send_any(OP_POP);
                end
            end else begin
                len = $urandom_range(10, 30);
                repeat (len) send_any(t_op'($urandom_range(OP_PUSH, OP_DUP)));
            end
            if ($urandom_range(0, 5) == 0) drain_dumps();
        end

        drain_dumps();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("rpn_stack_calculator_test passed");
        end else begin
            $display("rpn_stack_calculator_test failed");
        end
        $finish;
    end

endmodule
